### hdl/lpbd_pkg.sv
// Shared types and constants for the LRU page buffer directory.
// Used by the directory cell and the top level; depends on nothing else.
package lpbd_pkg;

  localparam int POOL_ENTRIES_DEF     = 10;
  localparam int PAGE_NUMBER_BITS_DEF = 20;
  localparam int SLOT_OUT_W           = 4;
  localparam int INIT_PAGES_W         = 21;

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_t;

  // Command broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic update;
    op_t  op;
    logic hit;
    logic full;
  } cmd_t;

  // Flags handed from one cell to the next along the row.
  typedef struct packed {
    logic hit;
    logic free_seen;
  } link_t;

endpackage

### hdl/lpbd_cell.sv
// One directory cell: page tag, valid bit and recency rank of a single slot.
// Depends on lpbd_pkg; instantiated in a row by lru_page_buffer_directory_core.
module lpbd_cell #(
  parameter int POOL_ENTRIES     = lpbd_pkg::POOL_ENTRIES_DEF,
  parameter int PAGE_NUMBER_BITS = lpbd_pkg::PAGE_NUMBER_BITS_DEF,
  parameter int CELL_INDEX       = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lpbd_pkg::cmd_t                    cmd,
  input  logic [PAGE_NUMBER_BITS-1:0]       page_in,
  input  logic [$clog2(POOL_ENTRIES)-1:0]   hit_rank,
  input  lpbd_pkg::link_t                   link_in,
  output lpbd_pkg::link_t                   link_out,
  input  logic [$clog2(POOL_ENTRIES)-1:0]   hit_slot_in,
  output logic [$clog2(POOL_ENTRIES)-1:0]   hit_slot_out,
  input  logic [$clog2(POOL_ENTRIES)-1:0]   hit_rank_in,
  output logic [$clog2(POOL_ENTRIES)-1:0]   hit_rank_out,
  input  logic [$clog2(POOL_ENTRIES)-1:0]   free_slot_in,
  output logic [$clog2(POOL_ENTRIES)-1:0]   free_slot_out,
  input  logic [$clog2(POOL_ENTRIES)-1:0]   victim_slot_in,
  output logic [$clog2(POOL_ENTRIES)-1:0]   victim_slot_out,
  input  logic [PAGE_NUMBER_BITS-1:0]       victim_page_in,
  output logic [PAGE_NUMBER_BITS-1:0]       victim_page_out
);
  import lpbd_pkg::*;

  localparam int SW = $clog2(POOL_ENTRIES);
  localparam logic [SW-1:0] MyIndex  = SW'(CELL_INDEX);
  localparam logic [SW-1:0] OldRank  = SW'(POOL_ENTRIES - 1);

  logic [PAGE_NUMBER_BITS-1:0] page;
  logic                        valid;
  logic [SW-1:0]               rank;
  logic                        valid_next;
  logic [SW-1:0]               rank_next;

  logic match;
  logic first_free;
  logic oldest;
  logic target;
  logic load;

  assign match      = valid && (page == page_in);
  assign first_free = !valid && !link_in.free_seen;
  assign oldest     = valid && (rank == OldRank);
  assign target     = cmd.full ? oldest : first_free;
  assign load       = cmd.update && (cmd.op == OP_ACCESS) && !cmd.hit && target;

  assign link_out.hit       = link_in.hit || match;
  assign link_out.free_seen = link_in.free_seen || !valid;
  assign hit_slot_out       = match ? MyIndex : hit_slot_in;
  assign hit_rank_out       = match ? rank : hit_rank_in;
  assign free_slot_out      = first_free ? MyIndex : free_slot_in;
  assign victim_slot_out    = oldest ? MyIndex : victim_slot_in;
  assign victim_page_out    = oldest ? page : victim_page_in;

  always_comb begin
    valid_next = valid;
    rank_next  = rank;
    if (cmd.update && (cmd.op == OP_ACCESS)) begin
      if (cmd.hit) begin
        if (match) begin
          rank_next = '0;
        end else if (valid && (rank < hit_rank)) begin
          rank_next = rank + 1'b1;
        end
      end else if (target) begin
        valid_next = 1'b1;
        rank_next  = '0;
      end else if (valid) begin
        rank_next = rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      valid <= valid_next;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      page <= page_in;
    end
  end

endmodule

### hdl/lru_page_buffer_directory_core.sv
// A request accepted at one clock edge moves the control state to execute; done is registered
// from the execute state and strobes the result after it. No new request is accepted while busy
// holds the compare-and-update step that runs through the row of directory cells.
// Reset clears every valid bit, every recency rank and the on-disk page count at once;
// there is no clearing pass. The result receiver cannot stall, so results are never held.
// Depends on lpbd_pkg and lpbd_cell.
module lru_page_buffer_directory_core #(
  parameter int POOL_ENTRIES     = lpbd_pkg::POOL_ENTRIES_DEF,
  parameter int PAGE_NUMBER_BITS = lpbd_pkg::PAGE_NUMBER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic [PAGE_NUMBER_BITS-1:0]         page_number,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpbd_pkg::INIT_PAGES_W-1:0]   initial_pages_on_disk,
  output logic                                done,
  output logic                                hit,
  output logic [lpbd_pkg::SLOT_OUT_W-1:0]     slot,
  output logic                                evict_valid,
  output logic [PAGE_NUMBER_BITS-1:0]         evict_page,
  output logic                                read_from_disk,
  output logic                                flush_written
);
  import lpbd_pkg::*;

  localparam int SW = $clog2(POOL_ENTRIES);
  // The on-disk page count must hold both the configured value and any page number plus one.
  localparam int DiskW = (PAGE_NUMBER_BITS + 1 > INIT_PAGES_W) ? PAGE_NUMBER_BITS + 1
                                                               : INIT_PAGES_W;

  // Control state and the captured request.
  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;
  op_t         op;
  logic [PAGE_NUMBER_BITS-1:0] page;
  logic [DiskW-1:0]            pages_on_disk;
  logic [DiskW-1:0]            pages_on_disk_next;

  // Chains along the row of cells; element 0 feeds the first cell.
  link_t                       link        [POOL_ENTRIES+1];
  logic [SW-1:0]               hit_slot    [POOL_ENTRIES+1];
  logic [SW-1:0]               hit_rank    [POOL_ENTRIES+1];
  logic [SW-1:0]               free_slot   [POOL_ENTRIES+1];
  logic [SW-1:0]               victim_slot [POOL_ENTRIES+1];
  logic [PAGE_NUMBER_BITS-1:0] victim_page [POOL_ENTRIES+1];

  cmd_t cmd;
  logic exec;
  logic found;
  logic full;
  logic miss_access;
  logic wb_en;
  logic [PAGE_NUMBER_BITS-1:0] wb_page;
  logic [DiskW-1:0]            wb_count;
  logic [DiskW-1:0]            page_ext;
  logic                        rd_now;
  logic [SW-1:0]               slot_now;

  assign accept    = start && !busy;
  assign busy      = (state == ST_EXEC);
  // Configuration is taken only between transactions so it never races a write-back.
  assign cfg_ready = !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= op_t'(action);
      page <= page_number;
    end
  end

  // The chain heads carry "nothing found yet".
  assign link[0]        = '0;
  assign hit_slot[0]    = '0;
  assign hit_rank[0]    = '0;
  assign free_slot[0]   = '0;
  assign victim_slot[0] = '0;
  assign victim_page[0] = '0;

  // The chain tail results come back to every cell as part of the broadcast command. Cell
  // outputs along the chain never depend on the command, so there is no combinational loop.
  assign exec  = busy;
  assign found = link[POOL_ENTRIES].hit;
  assign full  = !link[POOL_ENTRIES].free_seen;

  assign cmd.update = exec;
  assign cmd.op     = op;
  assign cmd.hit    = found;
  assign cmd.full   = full;

  for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
    lpbd_cell #(
      .POOL_ENTRIES    (POOL_ENTRIES),
      .PAGE_NUMBER_BITS(PAGE_NUMBER_BITS),
      .CELL_INDEX      (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .page_in        (page),
      .hit_rank       (hit_rank[POOL_ENTRIES]),
      .link_in        (link[i]),
      .link_out       (link[i+1]),
      .hit_slot_in    (hit_slot[i]),
      .hit_slot_out   (hit_slot[i+1]),
      .hit_rank_in    (hit_rank[i]),
      .hit_rank_out   (hit_rank[i+1]),
      .free_slot_in   (free_slot[i]),
      .free_slot_out  (free_slot[i+1]),
      .victim_slot_in (victim_slot[i]),
      .victim_slot_out(victim_slot[i+1]),
      .victim_page_in (victim_page[i]),
      .victim_page_out(victim_page[i+1])
    );
  end

  // A write-back happens on a flush that finds its page and on an access miss into a full
  // pool, where the least recent page (the one holding the top rank) leaves.
  assign miss_access = (op == OP_ACCESS) && !found;
  assign wb_en       = exec && (((op == OP_FLUSH) && found) || (miss_access && full));
  assign wb_page     = (op == OP_FLUSH) ? page : victim_page[POOL_ENTRIES];
  assign wb_count    = DiskW'(wb_page) + DiskW'(1);
  assign page_ext    = DiskW'(page);

  // The disk check on a miss sees the count after the eviction's write-back, so a page at
  // or below the evicted page number also counts as present on disk.
  assign rd_now = (page_ext < pages_on_disk)
                  || (full && (page <= victim_page[POOL_ENTRIES]));

  always_comb begin
    if (found) begin
      slot_now = hit_slot[POOL_ENTRIES];
    end else if (op == OP_FLUSH) begin
      slot_now = '0;
    end else if (full) begin
      slot_now = victim_slot[POOL_ENTRIES];
    end else begin
      slot_now = free_slot[POOL_ENTRIES];
    end
  end

  always_comb begin
    priority if (cfg_valid && cfg_ready) begin
      pages_on_disk_next = DiskW'(initial_pages_on_disk);
    end else if (wb_en && (wb_count > pages_on_disk)) begin
      pages_on_disk_next = wb_count;
    end else begin
      pages_on_disk_next = pages_on_disk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_on_disk <= '0;
      done          <= 1'b0;
    end else begin
      pages_on_disk <= pages_on_disk_next;
      done          <= exec;
    end
  end

  // Result registers; they only need to be right while done is high.
  always_ff @(posedge clk) begin
    if (exec) begin
      hit            <= found;
      slot           <= SLOT_OUT_W'(slot_now);
      evict_valid    <= miss_access && full;
      evict_page     <= (miss_access && full) ? victim_page[POOL_ENTRIES] : '0;
      read_from_disk <= miss_access && rd_now;
      flush_written  <= (op == OP_FLUSH) && found;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding execute cycle");

  a_single_exec: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute phase lasted more than one cycle");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evict_valid) |-> (!hit && !flush_written))
    else $error("eviction reported on a hit or a flush");

  a_flush_is_hit: assert property (@(posedge clk) disable iff (rst)
    (done && flush_written) |-> (hit && !read_from_disk))
    else $error("flush write-back reported without a cached page");

  a_disk_count_grows: assert property (@(posedge clk) disable iff (rst)
    (busy && !(cfg_valid && cfg_ready)) |=> (pages_on_disk >= $past(pages_on_disk)))
    else $error("on-disk page count shrank without a configuration write");
`endif

endmodule
